[design/mlrft_pkg.sv]
// Shared types and constants of the multi-lane race finish timer.
package mlrft_pkg;

    localparam int LANES      = 6;
    localparam int HIT_W      = 6;
    localparam int SCAN_LANES = (LANES < HIT_W) ? LANES : HIT_W;
    localparam int TIME_W     = 20;
    localparam int LANE_W     = 3;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [ADDR_W-1:0] REG_MIN_LAP    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_RACE_LIMIT = 3'd1;
    localparam logic [ADDR_W-1:0] REG_WAIT_FIRST = 3'd2;
    localparam logic [ADDR_W-1:0] REG_POS_VIEW   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_TIME_VIEW  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_HOLD       = 3'd5;

    localparam logic [TIME_W-1:0] RST_MIN_LAP    = 20'd500;
    localparam logic [TIME_W-1:0] RST_RACE_LIMIT = 20'd30000;
    localparam logic [TIME_W-1:0] RST_WAIT_FIRST = 20'd5000;
    localparam logic [TIME_W-1:0] RST_POS_VIEW   = 20'd3000;
    localparam logic [TIME_W-1:0] RST_TIME_VIEW  = 20'd3000;
    localparam logic [TIME_W-1:0] RST_HOLD       = 20'd6000;

    typedef enum logic [1:0] {
        MODE_ARMED  = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_RESULT = 2'd2
    } mode_t;

    typedef enum logic {
        OP_INC = 1'b0,
        OP_SUB = 1'b1
    } alu_op_t;

endpackage

[design/mlrft_alu.sv]
// Shared 20-bit adder: saturating increment, or subtract with a no-borrow flag.
module mlrft_alu
    import mlrft_pkg::*;
(
    input  alu_op_t           op,
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output logic [TIME_W-1:0] res,
    output logic              carry
);

    logic [TIME_W:0] sum;
    logic [TIME_W:0] addend;

    // Subtraction is a + ~b + 1; the carry out then means a >= b.
    assign addend = (op == OP_SUB) ? {1'b0, ~b} : '0;
    assign sum    = {1'b0, a} + addend + {{TIME_W{1'b0}}, 1'b1};
    assign carry  = sum[TIME_W];

    always_comb
    begin
        if (op == OP_INC && carry)
        begin
            res = TIME_MAX;
        end
        else
        begin
            res = sum[TIME_W-1:0];
        end
    end

endmodule

[design/multi_lane_race_finish_timer_core.sv]
// Top level of the race finish timer: tick sequencer, registers and output stage.
// Each input beat is one millisecond tick. The block answers every tick with
// the arrival records it causes, lane order first, then one status record that
// carries last. All timing arithmetic goes through one shared 20-bit adder, one
// operation per cycle, and the lanes are scanned one per cycle, except that a
// qualifying hit waits while the output beat is held by out_ready. in_ready is
// high only between ticks. The output register lets the next tick be taken
// while the status record still waits.
module multi_lane_race_finish_timer_core
    import mlrft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [TIME_W-1:0]  cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               gate_is_open,
    input  logic               gate_opened,
    input  logic               gate_closed,
    input  logic [HIT_W-1:0]   lane_hits,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               item_kind,
    output logic [LANE_W-1:0]  lane,
    output logic [2:0]         place,
    output logic [TIME_W-1:0]  elapsed_ms,
    output logic [1:0]         race_mode,
    output logic               view_phase,
    output logic [CNT_W-1:0]   arrived_count,
    output logic               last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RUN_INC,
        S_RUN_MIN,
        S_LANE,
        S_RUN_LIM,
        S_RUN_DIFF,
        S_RUN_WAIT,
        S_RES_PINC,
        S_RES_RINC,
        S_RES_PCMP,
        S_RES_HCMP,
        S_STATUS
    } state_t;

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(SCAN_LANES - 1);

    // Configuration registers.
    logic [TIME_W-1:0] min_lap_reg;
    logic [TIME_W-1:0] race_limit_reg;
    logic [TIME_W-1:0] wait_first_reg;
    logic [TIME_W-1:0] pos_view_reg;
    logic [TIME_W-1:0] time_view_reg;
    logic [TIME_W-1:0] hold_reg;

    // Sequencer and race state.
    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              phase_reg, phase_next;
    logic [TIME_W-1:0] race_clock_reg, race_clock_next;
    logic [HIT_W-1:0]  finished_reg, finished_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              first_seen_reg, first_seen_next;
    logic [TIME_W-1:0] first_time_reg, first_time_next;
    logic [TIME_W-1:0] phase_clock_reg, phase_clock_next;
    logic [TIME_W-1:0] result_clock_reg, result_clock_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              min_ok_reg, min_ok_next;
    logic              end_reg, end_next;
    logic [TIME_W-1:0] diff_reg, diff_next;

    // Latched tick.
    logic              is_open_reg, is_open_next;
    logic              closed_reg, closed_next;
    logic [HIT_W-1:0]  hits_reg, hits_next;

    // Output stage.
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [LANE_W-1:0] lane_out_reg, lane_out_next;
    logic [2:0]        place_reg, place_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [1:0]        mode_out_reg, mode_out_next;
    logic              phase_out_reg, phase_out_next;
    logic [CNT_W-1:0]  count_out_reg, count_out_next;
    logic              last_reg, last_next;

    // Shared adder.
    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_res;
    logic              alu_carry;

    logic              can_load;
    logic              hit_ok;
    logic [CNT_W-1:0]  count_inc;

    mlrft_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign can_load  = !out_valid_reg || out_ready;
    assign hit_ok    = hits_reg[lane_reg] && !finished_reg[lane_reg] && min_ok_reg;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        phase_next        = phase_reg;
        race_clock_next   = race_clock_reg;
        finished_next     = finished_reg;
        count_next        = count_reg;
        first_seen_next   = first_seen_reg;
        first_time_next   = first_time_reg;
        phase_clock_next  = phase_clock_reg;
        result_clock_next = result_clock_reg;
        lane_next         = lane_reg;
        min_ok_next       = min_ok_reg;
        end_next          = end_reg;
        diff_next         = diff_reg;
        is_open_next      = is_open_reg;
        closed_next       = closed_reg;
        hits_next         = hits_reg;

        out_valid_next    = out_valid_reg && !out_ready;
        kind_next         = kind_reg;
        lane_out_next     = lane_out_reg;
        place_next        = place_reg;
        elapsed_next      = elapsed_reg;
        mode_out_next     = mode_out_reg;
        phase_out_next    = phase_out_reg;
        count_out_next    = count_out_reg;
        last_next         = last_reg;

        alu_op = OP_SUB;
        alu_a  = race_clock_reg;
        alu_b  = min_lap_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    is_open_next = gate_is_open;
                    closed_next  = gate_closed;
                    hits_next    = lane_hits;
                    if (mode_reg == MODE_RUN)
                    begin
                        state_next = S_RUN_INC;
                    end
                    else if (mode_reg == MODE_RESULT)
                    begin
                        state_next = S_RES_PINC;
                    end
                    else
                    begin
                        mode_next = MODE_ARMED;
                        if (gate_opened)
                        begin
                            mode_next       = MODE_RUN;
                            race_clock_next = '0;
                            finished_next   = '0;
                            count_next      = '0;
                            first_seen_next = 1'b0;
                            first_time_next = '0;
                        end
                        state_next = S_STATUS;
                    end
                end
            end
            S_RUN_INC:
            begin
                alu_op          = OP_INC;
                race_clock_next = alu_res;
                state_next      = S_RUN_MIN;
            end
            S_RUN_MIN:
            begin
                min_ok_next = alu_carry;
                lane_next   = '0;
                state_next  = S_LANE;
            end
            S_LANE:
            begin
                // A qualifying hit waits here until the output register is free.
                if (!hit_ok || can_load)
                begin
                    if (hit_ok)
                    begin
                        finished_next[lane_reg] = 1'b1;
                        count_next              = count_inc;
                        if (!first_seen_reg)
                        begin
                            first_seen_next = 1'b1;
                            first_time_next = race_clock_reg;
                        end
                        out_valid_next = 1'b1;
                        kind_next      = 1'b0;
                        lane_out_next  = lane_reg;
                        place_next     = count_inc;
                        elapsed_next   = race_clock_reg;
                        mode_out_next  = mode_reg;
                        phase_out_next = phase_reg;
                        count_out_next = count_inc;
                        last_next      = 1'b0;
                    end
                    if (lane_reg == LANE_LAST)
                    begin
                        state_next = S_RUN_LIM;
                    end
                    else
                    begin
                        lane_next = lane_reg + 1'b1;
                    end
                end
            end
            S_RUN_LIM:
            begin
                alu_b      = race_limit_reg;
                end_next   = alu_carry || ({1'b0, count_reg} >= (CNT_W + 1)'(LANES));
                state_next = S_RUN_DIFF;
            end
            S_RUN_DIFF:
            begin
                alu_b      = first_time_reg;
                diff_next  = alu_res;
                state_next = S_RUN_WAIT;
            end
            S_RUN_WAIT:
            begin
                alu_a = diff_reg;
                alu_b = wait_first_reg;
                if (end_reg || (first_seen_reg && alu_carry))
                begin
                    mode_next         = MODE_RESULT;
                    phase_next        = 1'b0;
                    phase_clock_next  = '0;
                    result_clock_next = '0;
                end
                state_next = S_STATUS;
            end
            S_RES_PINC:
            begin
                alu_op           = OP_INC;
                alu_a            = phase_clock_reg;
                phase_clock_next = alu_res;
                state_next       = S_RES_RINC;
            end
            S_RES_RINC:
            begin
                alu_op            = OP_INC;
                alu_a             = result_clock_reg;
                result_clock_next = alu_res;
                state_next        = S_RES_PCMP;
            end
            S_RES_PCMP:
            begin
                alu_a = phase_clock_reg;
                alu_b = phase_reg ? time_view_reg : pos_view_reg;
                if (alu_carry)
                begin
                    phase_next       = !phase_reg;
                    phase_clock_next = '0;
                end
                state_next = S_RES_HCMP;
            end
            S_RES_HCMP:
            begin
                alu_a = result_clock_reg;
                alu_b = hold_reg;
                if (closed_reg || (!is_open_reg && alu_carry))
                begin
                    mode_next       = MODE_ARMED;
                    race_clock_next = '0;
                    finished_next   = '0;
                    count_next      = '0;
                    first_seen_next = 1'b0;
                    first_time_next = '0;
                end
                state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    lane_out_next  = '0;
                    place_next     = '0;
                    elapsed_next   = race_clock_reg;
                    mode_out_next  = mode_reg;
                    phase_out_next = phase_reg;
                    count_out_next = count_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lap_reg      <= RST_MIN_LAP;
            race_limit_reg   <= RST_RACE_LIMIT;
            wait_first_reg   <= RST_WAIT_FIRST;
            pos_view_reg     <= RST_POS_VIEW;
            time_view_reg    <= RST_TIME_VIEW;
            hold_reg         <= RST_HOLD;
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_ARMED;
            phase_reg        <= 1'b0;
            race_clock_reg   <= '0;
            finished_reg     <= '0;
            count_reg        <= '0;
            first_seen_reg   <= 1'b0;
            first_time_reg   <= '0;
            phase_clock_reg  <= '0;
            result_clock_reg <= '0;
            lane_reg         <= '0;
            min_ok_reg       <= 1'b0;
            end_reg          <= 1'b0;
            diff_reg         <= '0;
            is_open_reg      <= 1'b0;
            closed_reg       <= 1'b0;
            hits_reg         <= '0;
            out_valid_reg    <= 1'b0;
            kind_reg         <= 1'b0;
            lane_out_reg     <= '0;
            place_reg        <= '0;
            elapsed_reg      <= '0;
            mode_out_reg     <= '0;
            phase_out_reg    <= 1'b0;
            count_out_reg    <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MIN_LAP:    min_lap_reg    <= cfg_wdata;
                    REG_RACE_LIMIT: race_limit_reg <= cfg_wdata;
                    REG_WAIT_FIRST: wait_first_reg <= cfg_wdata;
                    REG_POS_VIEW:   pos_view_reg   <= cfg_wdata;
                    REG_TIME_VIEW:  time_view_reg  <= cfg_wdata;
                    REG_HOLD:       hold_reg       <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            phase_reg        <= phase_next;
            race_clock_reg   <= race_clock_next;
            finished_reg     <= finished_next;
            count_reg        <= count_next;
            first_seen_reg   <= first_seen_next;
            first_time_reg   <= first_time_next;
            phase_clock_reg  <= phase_clock_next;
            result_clock_reg <= result_clock_next;
            lane_reg         <= lane_next;
            min_ok_reg       <= min_ok_next;
            end_reg          <= end_next;
            diff_reg         <= diff_next;
            is_open_reg      <= is_open_next;
            closed_reg       <= closed_next;
            hits_reg         <= hits_next;
            out_valid_reg    <= out_valid_next;
            kind_reg         <= kind_next;
            lane_out_reg     <= lane_out_next;
            place_reg        <= place_next;
            elapsed_reg      <= elapsed_next;
            mode_out_reg     <= mode_out_next;
            phase_out_reg    <= phase_out_next;
            count_out_reg    <= count_out_next;
            last_reg         <= last_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign item_kind     = kind_reg;
    assign lane          = lane_out_reg;
    assign place         = place_reg;
    assign elapsed_ms    = elapsed_reg;
    assign race_mode     = mode_out_reg;
    assign view_phase    = phase_out_reg;
    assign arrived_count = count_out_reg;
    assign last          = last_reg;

endmodule
